>>> rtl/core/nfpe_pkg.sv
// ---------------------------------------------------------------------------
// nfpe_pkg
// Types, request codes and modular add/subtract helpers for the Newton-form
// polynomial evaluator.
// ---------------------------------------------------------------------------
package nfpe_pkg;

    localparam int unsigned DW = 63;

    localparam logic [1:0] REQ_WR_COEF  = 2'd0;
    localparam logic [1:0] REQ_WR_NODE  = 2'd1;
    localparam logic [1:0] REQ_EVAL     = 2'd2;
    localparam logic [1:0] REQ_ROW      = 2'd3;

    localparam logic CFG_MODULUS = 1'b0;
    localparam logic CFG_DEGREE  = 1'b1;

    localparam logic [DW-1:0] MODULUS_RESET = 63'h7FFF_FFFF_FFFF_FFE7;

    typedef struct packed {
        logic [1:0]    req_type;
        logic [6:0]    index;
        logic [DW-1:0] operand;
    } t_req;

    typedef struct packed {
        logic [DW-1:0] value;
        logic [DW-1:0] eta;
        logic          status;
    } t_rsp;

    function automatic logic [DW-1:0] madd(input logic [DW-1:0] a,
                                           input logic [DW-1:0] b,
                                           input logic [DW-1:0] m);
        logic [DW:0] s;
        logic [DW:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - {1'b0, m};
        madd = (s >= {1'b0, m}) ? d[DW-1:0] : s[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] msub(input logic [DW-1:0] a,
                                           input logic [DW-1:0] b,
                                           input logic [DW-1:0] m);
        logic [DW-1:0] d;
        d = a - b;
        msub = (a >= b) ? d : d + m;
    endfunction

endpackage

>>> rtl/core/nfpe_ram.sv
// ---------------------------------------------------------------------------
// nfpe_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module nfpe_ram #(
    parameter int unsigned WIDTH = 63,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/nfpe_mulmod.sv
// ---------------------------------------------------------------------------
// nfpe_mulmod
// Bit-serial modular multiplier: double then conditional add, one
// compare-subtract per cycle, multiplier bits shifted out MSB first.
// ---------------------------------------------------------------------------
module nfpe_mulmod (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [nfpe_pkg::DW-1:0] i_a,
    input  logic [nfpe_pkg::DW-1:0] i_b,
    input  logic [nfpe_pkg::DW-1:0] i_m,
    output logic                   o_done,
    output logic [nfpe_pkg::DW-1:0] o_r
);
    import nfpe_pkg::*;

    logic          r_busy;
    logic          r_phase;
    logic          r_done;
    logic [5:0]    r_cnt;
    logic [DW-1:0] r_a;
    logic [DW-1:0] r_b;
    logic [DW-1:0] r_r;
    logic [DW-1:0] r_m;
    logic [DW-1:0] addend;

    assign addend = r_phase ? (r_b[DW-1] ? r_a : '0) : r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
            end else if (r_busy) begin
                r_phase <= ~r_phase;
                if (r_phase && r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
            r_r   <= '0;
            r_cnt <= 6'(DW - 1);
        end else if (r_busy) begin
            r_r <= madd(r_r, addend, r_m);
            if (r_phase) begin
                r_b   <= {r_b[DW-2:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_r    = r_r;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !$past(i_start) |-> r_r < r_m) else $error("accumulator unreduced");
`endif

endmodule

>>> rtl/core/newton_form_poly_eval_mod_unit.sv
// ---------------------------------------------------------------------------
// newton_form_poly_eval_mod_unit
// Newton-form polynomial store and evaluator over a prime field.
//
//   channel   direction  handshake                 payload
//   request   in         start & !busy             i_req   (t_req)
//   result    out        o_strobe, one cycle       o_rsp   (t_rsp)
//   config    in         i_cfg_valid & o_cfg_ready i_cfg_index, i_cfg_data
//
// A write's result strobes the next cycle.
// Every modular multiply or reduction runs on one bit-serial unit.
// Synchronous active-low reset; stores hold garbage until written.
// The result cannot be stalled; busy holds off new requests.
// ---------------------------------------------------------------------------
module newton_form_poly_eval_mod_unit #(
    parameter int unsigned MAX_TERMS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  nfpe_pkg::t_req  i_req,
    output logic            busy,
    output logic            o_strobe,
    output nfpe_pkg::t_rsp  o_rsp,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic            i_cfg_index,
    input  logic [nfpe_pkg::DW-1:0] i_cfg_data
);
    import nfpe_pkg::*;

    localparam int unsigned AW = $clog2(MAX_TERMS);
    localparam int unsigned IW = $clog2(MAX_TERMS + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_XRED    = 4'd1;
    localparam logic [3:0] S_FCRED_W = 4'd2;
    localparam logic [3:0] S_FWAIT   = 4'd3;
    localparam logic [3:0] S_FNRED   = 4'd4;
    localparam logic [3:0] S_FNRED_W = 4'd5;
    localparam logic [3:0] S_FMUL_W  = 4'd6;
    localparam logic [3:0] S_RCMUL_W = 4'd7;
    localparam logic [3:0] S_RNRED_W = 4'd8;
    localparam logic [3:0] S_RTMUL_W = 4'd9;
    localparam logic [3:0] S_RWAIT   = 4'd10;
    localparam logic [3:0] S_RCMUL   = 4'd11;

    logic [3:0]    r_state, n_state;
    logic          r_isrow, n_isrow;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_lim, n_lim;
    logic [DW-1:0] r_x, n_x;
    logic [DW-1:0] r_res, n_res;
    logic [DW-1:0] r_term, n_term;
    logic [DW-1:0] r_m, n_m;
    logic [DW-1:0] r_one, n_one;
    logic          r_strobe, n_strobe;
    logic [DW-1:0] r_value, n_value;
    logic [DW-1:0] r_eta, n_eta;
    logic          r_status, n_status;
    logic [DW-1:0] r_modulus;
    logic [5:0]    r_degree;

    logic          accept;
    logic [DW-1:0] m_c;
    logic [DW-1:0] one_c;
    logic          wr_ok;
    logic          coef_we;
    logic          node_we;
    logic [DW-1:0] coef_rd;
    logic [DW-1:0] node_rd;
    logic          mul_start;
    logic [DW-1:0] mul_a;
    logic [DW-1:0] mul_b;
    logic [DW-1:0] mul_m;
    logic          mul_done;
    logic [DW-1:0] mul_r;
    logic [DW-1:0] sum_c;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign m_c    = (r_modulus == '0) ? DW'(1) : r_modulus;
    assign one_c  = (m_c == DW'(1)) ? '0 : DW'(1);
    assign wr_ok  = 32'(i_req.index) < MAX_TERMS;
    assign coef_we = accept && i_req.req_type == REQ_WR_COEF && wr_ok;
    assign node_we = accept && i_req.req_type == REQ_WR_NODE && wr_ok;
    assign mul_m  = (r_state == S_IDLE) ? m_c : r_m;
    assign sum_c  = madd(r_res, mul_r, r_m);

    nfpe_ram #(.WIDTH(DW), .DEPTH(MAX_TERMS)) u_coef (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (AW'(i_req.index)),
        .i_wdata (i_req.operand),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (coef_rd)
    );

    nfpe_ram #(.WIDTH(DW), .DEPTH(MAX_TERMS)) u_node (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (AW'(i_req.index)),
        .i_wdata (i_req.operand),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (node_rd)
    );

    nfpe_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_m     (mul_m),
        .o_done  (mul_done),
        .o_r     (mul_r)
    );

    always_comb begin
        n_state  = r_state;
        n_isrow  = r_isrow;
        n_i      = r_i;
        n_lim    = r_lim;
        n_x      = r_x;
        n_res    = r_res;
        n_term   = r_term;
        n_m      = r_m;
        n_one    = r_one;
        n_strobe = 1'b0;
        n_value  = r_value;
        n_eta    = r_eta;
        n_status = r_status;
        mul_start = 1'b0;
        mul_a     = r_one;
        mul_b     = coef_rd;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_m      = m_c;
                    n_one    = one_c;
                    n_res    = '0;
                    n_term   = one_c;
                    n_value  = '0;
                    n_eta    = '0;
                    n_status = 1'b0;
                    case (i_req.req_type)
                        REQ_EVAL: begin
                            if (32'(r_degree) >= MAX_TERMS) begin
                                n_strobe = 1'b1;
                                n_status = 1'b1;
                            end else begin
                                n_isrow   = 1'b0;
                                n_i       = IW'(r_degree);
                                mul_start = 1'b1;
                                mul_a     = one_c;
                                mul_b     = i_req.operand;
                                n_state   = S_XRED;
                            end
                        end
                        REQ_ROW: begin
                            if (32'(i_req.index) > MAX_TERMS) begin
                                n_strobe = 1'b1;
                                n_status = 1'b1;
                            end else begin
                                n_isrow   = 1'b1;
                                n_i       = '0;
                                n_lim     = IW'(i_req.index);
                                mul_start = 1'b1;
                                mul_a     = one_c;
                                mul_b     = i_req.operand;
                                n_state   = S_XRED;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_status = !wr_ok;
                        end
                    endcase
                end
            end
            S_XRED: begin
                if (mul_done) begin
                    n_x = mul_r;
                    if (r_isrow) begin
                        if (r_lim == '0) begin
                            n_strobe = 1'b1;
                            n_value  = '0;
                            n_eta    = r_term;
                            n_state  = S_IDLE;
                        end else begin
                            mul_start = 1'b1;
                            mul_a     = r_term;
                            mul_b     = coef_rd;
                            n_state   = S_RCMUL_W;
                        end
                    end else begin
                        mul_start = 1'b1;
                        n_state   = S_FCRED_W;
                    end
                end
            end
            S_FCRED_W: begin
                if (mul_done) begin
                    n_res = sum_c;
                    if (r_i == '0) begin
                        n_strobe = 1'b1;
                        n_value  = sum_c;
                        n_state  = S_IDLE;
                    end else begin
                        n_i     = r_i - IW'(1);
                        n_state = S_FWAIT;
                    end
                end
            end
            S_FWAIT: begin
                n_state = S_FNRED;
            end
            S_FNRED: begin
                mul_start = 1'b1;
                mul_b     = node_rd;
                n_state   = S_FNRED_W;
            end
            S_FNRED_W: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = r_res;
                    mul_b     = msub(r_x, mul_r, r_m);
                    n_state   = S_FMUL_W;
                end
            end
            S_FMUL_W: begin
                if (mul_done) begin
                    n_res     = mul_r;
                    mul_start = 1'b1;
                    n_state   = S_FCRED_W;
                end
            end
            S_RCMUL: begin
                mul_start = 1'b1;
                mul_a     = r_term;
                n_state   = S_RCMUL_W;
            end
            S_RCMUL_W: begin
                if (mul_done) begin
                    n_res     = sum_c;
                    mul_start = 1'b1;
                    mul_b     = node_rd;
                    n_state   = S_RNRED_W;
                end
            end
            S_RNRED_W: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = r_term;
                    mul_b     = msub(r_x, mul_r, r_m);
                    n_state   = S_RTMUL_W;
                end
            end
            S_RTMUL_W: begin
                if (mul_done) begin
                    n_term = mul_r;
                    if (r_i + IW'(1) == r_lim) begin
                        n_strobe = 1'b1;
                        n_value  = r_res;
                        n_eta    = mul_r;
                        n_state  = S_IDLE;
                    end else begin
                        n_i     = r_i + IW'(1);
                        n_state = S_RWAIT;
                    end
                end
            end
            S_RWAIT: begin
                n_state = S_RCMUL;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_strobe  <= 1'b0;
            r_i       <= '0;
            r_modulus <= MODULUS_RESET;
            r_degree  <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_i      <= n_i;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MODULUS: r_modulus <= i_cfg_data;
                    CFG_DEGREE:  r_degree  <= i_cfg_data[5:0];
                    default:     r_degree  <= r_degree;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_isrow  <= n_isrow;
        r_lim    <= n_lim;
        r_x      <= n_x;
        r_res    <= n_res;
        r_term   <= n_term;
        r_m      <= n_m;
        r_one    <= n_one;
        r_value  <= n_value;
        r_eta    <= n_eta;
        r_status <= n_status;
    end

    assign o_cfg_ready  = 1'b1;
    assign o_strobe     = r_strobe;
    assign o_rsp.value  = r_value;
    assign o_rsp.eta    = r_eta;
    assign o_rsp.status = r_status;

`ifndef SYNTHESIS
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy) else $error("result while busy");
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> 32'(r_i) <= MAX_TERMS) else $error("term index out of range");
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_rsp.status |-> o_rsp.value == '0 && o_rsp.eta == '0)
        else $error("error result not zero");
`endif

endmodule

>>> test/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for newton_form_poly_eval_mod_unit. It preloads both
// stores, walks a table of directed requests, then runs random phases under
// several modulus and degree settings. A local Newton-form evaluator predicts
// the responses the table does not give; a monitor checks each strobed response.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nfpe_pkg::*;

    localparam int unsigned TERMS     = 64;
    localparam int unsigned STALL_MAX = 200000;
    localparam logic [DW-1:0] ALL_ONES = {DW{1'b1}};

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_case;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    t_req           i_req = '0;
    logic           busy;
    logic           o_strobe;
    t_rsp           o_rsp;
    logic           i_cfg_valid = 1'b0;
    logic           o_cfg_ready;
    logic           i_cfg_index = CFG_MODULUS;
    logic [DW-1:0]  i_cfg_data = '0;

    logic [DW-1:0]  coef_mirror [TERMS];
    logic [DW-1:0]  node_mirror [TERMS];
    logic [DW-1:0]  modulus_mirror = MODULUS_RESET;
    logic [5:0]     degree_mirror = '0;

    t_rsp           pending_rsp [$];
    t_case          directed [$];
    int             errors = 0;
    int             stall_cycles = 0;
    int             requests_sent = 0;
    int             responses_seen = 0;
    bit             quiet_sender = 1'b0;

    newton_form_poly_eval_mod_unit #(.MAX_TERMS(TERMS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .o_strobe    (o_strobe),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [DW-1:0] mul_mod(logic [DW-1:0] a, logic [DW-1:0] b,
                                              logic [DW-1:0] m);
        logic [2*DW-1:0] p;
        p = {{DW{1'b0}}, a} * {{DW{1'b0}}, b};
        return DW'(p % {{DW{1'b0}}, m});
    endfunction

    function automatic logic [DW-1:0] sub_mod(logic [DW-1:0] a, logic [DW-1:0] b,
                                              logic [DW-1:0] m);
        logic [DW:0] d;
        d = (a >= b) ? {1'b0, a} - {1'b0, b} : {1'b0, a} + {1'b0, m} - {1'b0, b};
        return d[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] add_mod(logic [DW-1:0] a, logic [DW-1:0] b,
                                              logic [DW-1:0] m);
        logic [DW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) s = s - {1'b0, m};
        return s[DW-1:0];
    endfunction

    // Apply one accepted request to the mirrored stores and return its response.
    function automatic t_rsp newton_predict(t_req r);
        t_rsp          rsp;
        logic [DW-1:0] m;
        logic [DW-1:0] x;
        logic [DW-1:0] acc;
        logic [DW-1:0] term;
        rsp = '0;
        m = (modulus_mirror == 0) ? DW'(1) : modulus_mirror;
        x = r.operand % m;
        case (r.req_type)
            REQ_WR_COEF, REQ_WR_NODE: begin
                if (r.index >= TERMS) rsp.status = 1'b1;
                else if (r.req_type == REQ_WR_COEF) coef_mirror[r.index[5:0]] = r.operand;
                else node_mirror[r.index[5:0]] = r.operand;
            end
            REQ_EVAL: begin
                acc = coef_mirror[degree_mirror] % m;
                for (int i = int'(degree_mirror) - 1; i >= 0; i--) begin
                    acc = mul_mod(acc, sub_mod(x, node_mirror[i] % m, m), m);
                    acc = add_mod(acc, coef_mirror[i] % m, m);
                end
                rsp.value = acc;
            end
            default: begin
                if (r.index > TERMS) begin
                    rsp.status = 1'b1;
                end else begin
                    acc = '0;
                    term = DW'(1) % m;
                    for (int i = 0; i < int'(r.index); i++) begin
                        acc = add_mod(acc, mul_mod(coef_mirror[i] % m, term, m), m);
                        term = mul_mod(term, sub_mod(x, node_mirror[i] % m, m), m);
                    end
                    rsp.value = acc;
                    rsp.eta = term;
                end
            end
        endcase
        return rsp;
    endfunction

    task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
        errors++;
        $display("ERROR @%0t response %0d: %s got %0d expected %0d",
                 $realtime, responses_seen, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_strobe) begin
            responses_seen++;
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected response", o_rsp.value, '0);
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.value !== want.value) report_mismatch("value", o_rsp.value, want.value);
                if (o_rsp.eta !== want.eta) report_mismatch("eta", o_rsp.eta, want.eta);
                if (o_rsp.status !== want.status)
                    report_mismatch("status", DW'(o_rsp.status), DW'(want.status));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Drop start, then hold until every expected response has come.
    task automatic drain();
        start <= 1'b0;
        while (pending_rsp.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_register(logic idx, logic [DW-1:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_MODULUS) modulus_mirror = data;
        else degree_mirror = data[5:0];
    endtask

    // Present one request, hold it until accepted, then record its response.
    task automatic send_request(t_req r, bit typed = 1'b0, t_rsp typed_rsp = '0);
        t_rsp predicted;
        if (!quiet_sender && $urandom_range(99) < 36) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        predicted = newton_predict(r);
        pending_rsp.insert(pending_rsp.size(), typed ? typed_rsp : predicted);
        requests_sent++;
    endtask

    function automatic void add_directed(t_case c);
        directed.insert(directed.size(), c);
    endfunction

    function automatic logic [DW-1:0] random_word();
        case ($urandom_range(9))
            0: return '0;
            1: return ALL_ONES;
            default: return DW'({$urandom(), $urandom()});
        endcase
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   pick;
        r.operand = random_word();
        pick = $urandom_range(99);
        if (pick < 50) begin
            r.req_type = (pick < 25) ? REQ_WR_COEF : REQ_WR_NODE;
            r.index = ($urandom_range(9) == 0) ? 7'($urandom_range(64, 127))
                                               : 7'($urandom_range(0, 63));
        end else if (pick < 75) begin
            r.req_type = REQ_EVAL;
            r.index = 7'($urandom());
        end else begin
            r.req_type = REQ_ROW;
            pick = $urandom_range(99);
            if (pick < 80) r.index = 7'($urandom_range(0, 6));
            else if (pick < 84) r.index = 7'(TERMS);
            else if (pick < 88) r.index = 7'($urandom_range(7, 63));
            else r.index = 7'($urandom_range(65, 127));
        end
        return r;
    endfunction

    function automatic t_case make_case(logic [1:0] kind, int idx, logic [DW-1:0] opnd,
                                        bit typed = 1'b0, logic [DW-1:0] value = '0,
                                        logic [DW-1:0] eta = '0, bit status = 1'b0);
        t_case c;
        c.req = '{req_type: kind, index: 7'(idx), operand: opnd};
        c.typed = typed;
        c.rsp = '{value: value, eta: eta, status: status};
        return c;
    endfunction

    initial begin
        logic [DW-1:0] phase_mod [6];
        logic [5:0]    phase_deg [6];
        int            phase_len [6];

        phase_mod = '{MODULUS_RESET, 63'd2, ALL_ONES, 63'd0, 63'd1, 63'd1000003};
        phase_deg = '{6'd3, 6'd0, 6'd63, 6'd5, 6'd2, 6'd4};
        phase_len = '{250, 120, 20, 100, 80, 250};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < TERMS; i++) begin
            send_request('{req_type: REQ_WR_COEF, index: 7'(i), operand: random_word()});
            send_request('{req_type: REQ_WR_NODE, index: 7'(i), operand: random_word()});
        end

        add_directed(make_case(REQ_WR_COEF, 0, ALL_ONES, 1'b1));
        add_directed(make_case(REQ_WR_COEF, 63, '0, 1'b1));
        add_directed(make_case(REQ_WR_NODE, 0, '0, 1'b1));
        add_directed(make_case(REQ_WR_NODE, 63, ALL_ONES, 1'b1));
        add_directed(make_case(REQ_WR_COEF, 64, ALL_ONES, 1'b1, '0, '0, 1'b1));
        add_directed(make_case(REQ_WR_NODE, 127, ALL_ONES, 1'b1, '0, '0, 1'b1));
        add_directed(make_case(REQ_EVAL, 0, '0));
        add_directed(make_case(REQ_EVAL, 0, ALL_ONES));
        add_directed(make_case(REQ_EVAL, 0, MODULUS_RESET));
        add_directed(make_case(REQ_ROW, 0, 63'd12345, 1'b1, '0, 63'd1));
        add_directed(make_case(REQ_ROW, 1, ALL_ONES));
        add_directed(make_case(REQ_ROW, 3, 63'd7));
        add_directed(make_case(REQ_ROW, 64, 63'h5555_5555_5555_5555));
        add_directed(make_case(REQ_ROW, 65, ALL_ONES, 1'b1, '0, '0, 1'b1));
        add_directed(make_case(REQ_ROW, 127, '0, 1'b1, '0, '0, 1'b1));

        foreach (directed[i]) send_request(directed[i].req, directed[i].typed, directed[i].rsp);

        write_register(CFG_DEGREE, 63'd63);
        send_request('{req_type: REQ_EVAL, index: 7'd0, operand: ALL_ONES});

        for (int p = 0; p < 6; p++) begin
            write_register(CFG_MODULUS, phase_mod[p]);
            write_register(CFG_DEGREE, {57'd0, phase_deg[p]});
            for (int n = 0; n < phase_len[p]; n++) begin
                quiet_sender = (p == 0 && n >= 80 && n < 200);
                send_request(random_request());
                if (p == 5 && n == 120) begin
                    drain();
                end
            end
            quiet_sender = 1'b0;
        end

        drain();
        repeat (200) @(posedge i_clk);

        $display("Covered %0d requests and %0d responses: writes, full and row evaluation,",
                 requests_sent, responses_seen);
        $display("out-of-range indexes, and moduli 0, 1, 2, reset, max and a small prime.");
        if (errors == 0 && pending_rsp.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/nfpe_pkg.sv
rtl/core/nfpe_ram.sv
rtl/core/nfpe_mulmod.sv
rtl/core/newton_form_poly_eval_mod_unit.sv
test/testbench.sv
